/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    // Field widths fixed by the item format
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 8;
    localparam int DESC_W   = 32;
    localparam int STATUS_W = 2;

    // Upper bound on the number of items one view produces
    localparam int MAX_RESULTS = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_VIEW   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    // One stored task
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [DESC_W-1:0] desc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Action applied by every cell in one cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    // Command broadcast to the whole chain
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_cmd_t;

    // Link from one cell to its neighbours
    typedef struct packed {
        logic   valid;
        logic   ge;
        entry_t entry;
    } cell_link_t;

endpackage

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_cmd_t  cmd,
    input  cell_link_t prev_link,
    input  cell_link_t next_link,
    input  logic       hit_in,
    output cell_link_t link,
    output logic       hit_out,
    output logic       first
);

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   ge;
    logic   match;

    // Compare the stored task against the broadcast one
    assign ge      = valid_reg && (entry_reg.prio >= cmd.new_entry.prio);
    assign match   = valid_reg && (entry_reg.id == cmd.new_entry.id);
    assign hit_out = hit_in | match;
    assign first   = match & ~hit_in;

    assign link.valid = valid_reg;
    assign link.ge    = ge;
    assign link.entry = entry_reg;

    // Choose the next content: keep, take new, take from a neighbour
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        unique case (cmd.op)
            OP_ADD:
            begin
                if (!ge)
                begin
                    entry_next = prev_link.ge ? cmd.new_entry : prev_link.entry;
                    valid_next = valid_reg | prev_link.valid;
                end
            end
            OP_REMOVE:
            begin
                if (hit_out)
                begin
                    entry_next = next_link.entry;
                    valid_next = next_link.valid;
                end
            end
            OP_ROTATE:
            begin
                entry_next = next_link.entry;
                valid_next = next_link.valid;
            end
            OP_HOLD:
            begin
                valid_next = valid_reg;
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold task payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/sorted_priority_task_queue_unit.sv */
`timescale 1ns / 1ps

// Sorted priority task queue. Tasks sit in a chain of QUEUE_DEPTH cells in
// descending priority order; equal priorities leave first in, first out.
// An item is taken when start is high and busy is low; busy stays high until
// the item finishes. Add, pop and remove by id give a single result on the
// cycle after the item finishes, marked by done for one cycle. View rotates
// the whole chain one cell per cycle and gives one result per stored task
// (at most MAX_RESULTS), one per cycle, with last on the final one; an empty
// queue gives one STATUS_EMPTY result instead. Results cannot be held off:
// the receiver must take every result in the cycle it is shown.

module sorted_priority_task_queue_unit
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [ID_W-1:0]     task_id,
    input  logic [PRIO_W-1:0]   task_priority,
    input  logic [DESC_W-1:0]   desc_handle,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     out_id,
    output logic [PRIO_W-1:0]   out_priority,
    output logic [DESC_W-1:0]   out_desc,
    output logic                last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int K_W   = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_VIEW = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [K_W-1:0]      view_k_reg;
    logic [K_W-1:0]      view_k_next;
    logic [FUNC_W-1:0]   func_reg;
    entry_t              cmd_entry_reg;

    logic                done_reg;
    logic                done_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    entry_t              res_entry_reg;
    entry_t              res_entry_next;
    logic                last_reg;
    logic                last_next;

    cell_cmd_t           cmd;
    cell_op_t            op;
    cell_link_t          links [QUEUE_DEPTH];
    logic                hits  [QUEUE_DEPTH+1];
    logic [QUEUE_DEPTH-1:0] firsts;
    logic [ENTRY_W-1:0]  found_vec;
    entry_t              found_entry;
    logic [CNT_W-1:0]    view_cnt;
    logic                accept;
    cell_link_t          head_link;
    cell_link_t          tail_link;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    assign cmd.op        = op;
    assign cmd.new_entry = cmd_entry_reg;

    // Pop shifts from the head; remove starts at the first match
    assign hits[0] = (func_reg == FUNC_POP);

    // Head of the chain takes the new task when no stored task ranks ahead
    assign head_link.valid = 1'b1;
    assign head_link.ge    = 1'b1;
    assign head_link.entry = cmd_entry_reg;

    // Tail refills from the head while rotating, else empties
    assign tail_link.valid = (op == OP_ROTATE) ? links[0].valid : 1'b0;
    assign tail_link.ge    = 1'b0;
    assign tail_link.entry = links[0].entry;

    // Build the chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .prev_link ((i == 0) ? head_link : links[(i == 0) ? 0 : i-1]),
            .next_link ((i == QUEUE_DEPTH-1) ? tail_link
                                             : links[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .hit_in    (hits[i]),
            .link      (links[i]),
            .hit_out   (hits[i+1]),
            .first     (firsts[i])
        );
    end

    // Gather the first matching task
    always_comb
    begin
        found_vec = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            found_vec = found_vec | (links[i].entry & {ENTRY_W{firsts[i]}});
        end
    end
    assign found_entry = entry_t'(found_vec);

    // Bound the number of listed tasks
    assign view_cnt = (32'(count_reg) < MAX_RESULTS) ? count_reg : CNT_W'(MAX_RESULTS);

    // Sequence commands and form results
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        view_k_next    = view_k_reg;
        op             = OP_HOLD;
        done_next      = 1'b0;
        status_next    = STATUS_OK;
        res_entry_next = '0;
        last_next      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                if (func_reg == FUNC_ADD)
                begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        op         = OP_ADD;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (count_reg == '0)
                begin
                    status_next = STATUS_EMPTY;
                end
                else if (func_reg == FUNC_POP)
                begin
                    op             = OP_REMOVE;
                    res_entry_next = links[0].entry;
                    count_next     = count_reg - CNT_W'(1);
                end
                else if (func_reg == FUNC_REMOVE)
                begin
                    if (hits[QUEUE_DEPTH])
                    begin
                        op             = OP_REMOVE;
                        res_entry_next = found_entry;
                        count_next     = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    done_next   = 1'b0;
                    view_k_next = '0;
                    state_next  = ST_VIEW;
                end
            end
            ST_VIEW:
            begin
                op = OP_ROTATE;
                if (CNT_W'(view_k_reg) < view_cnt)
                begin
                    done_next      = 1'b1;
                    res_entry_next = links[0].entry;
                    last_next      = ((CNT_W'(view_k_reg) + CNT_W'(1)) == view_cnt);
                end
                view_k_next = view_k_reg + K_W'(1);
                if (view_k_reg == K_W'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            view_k_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            view_k_reg <= view_k_next;
            done_reg   <= done_next;
        end
    end

    // Hold the accepted item and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg           <= func;
            cmd_entry_reg.id   <= task_id;
            cmd_entry_reg.prio <= task_priority;
            cmd_entry_reg.desc <= desc_handle;
        end
        status_reg    <= status_next;
        res_entry_reg <= res_entry_next;
        last_reg      <= last_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_id       = res_entry_reg.id;
    assign out_priority = res_entry_reg.prio;
    assign out_desc     = res_entry_reg.desc;
    assign last         = last_reg;

endmodule

/* sim/sorted_priority_task_queue_unit_test.sv */
`timescale 1ns / 1ps

module sorted_priority_task_queue_unit_test;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 330;
    localparam int QUIET_TAIL   = 60;

    // Phase kinds for the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct {
        logic [STATUS_W-1:0] status;
        entry_t              ent;
        logic                last;
    } queue_result_t;

    // Track the stored tasks and the results they should produce
    class queue_tracker;
        entry_t        stored[$];
        queue_result_t expected[$];
        int unsigned   failures;

        function void note_command(logic [FUNC_W-1:0] f, entry_t e);
            queue_result_t r;
            int            pos;
            int            cnt;
            r.status = STATUS_OK;
            r.ent    = '0;
            r.last   = 1'b1;
            if (f == FUNC_ADD)
            begin
                // Insert behind every task of equal or higher priority
                if (stored.size() >= QUEUE_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    pos = 0;
                    while (pos < stored.size() && stored[pos].prio >= e.prio)
                        pos++;
                    stored.insert(pos, e);
                end
                expected.push_back(r);
            end
            else if (stored.size() == 0)
            begin
                r.status = STATUS_EMPTY;
                expected.push_back(r);
            end
            else if (f == FUNC_POP)
            begin
                r.ent = stored.pop_front();
                expected.push_back(r);
            end
            else if (f == FUNC_REMOVE)
            begin
                // Drop the first match from the head
                pos = 0;
                while (pos < stored.size() && stored[pos].id != e.id)
                    pos++;
                if (pos >= stored.size())
                    r.status = STATUS_NOT_FOUND;
                else
                begin
                    r.ent = stored[pos];
                    stored.delete(pos);
                end
                expected.push_back(r);
            end
            else
            begin
                // List from the head, marking the final task shown
                cnt = (stored.size() < MAX_RESULTS) ? stored.size() : MAX_RESULTS;
                for (int i = 0; i < cnt; i++)
                begin
                    r.ent  = stored[i];
                    r.last = (i == cnt - 1);
                    expected.push_back(r);
                end
            end
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, want, got);
            failures++;
        endfunction

        function void check_result(queue_result_t got);
            queue_result_t want;
            if (expected.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, status %0h id %0h prio %0h desc %0h",
                         $time, got.status, got.ent.id, got.ent.prio, got.ent.desc);
                failures++;
                return;
            end
            want = expected.pop_front();
            if (got.status !== want.status)
                report("status", 64'(want.status), 64'(got.status));
            if (got.ent.id !== want.ent.id)
                report("out_id", 64'(want.ent.id), 64'(got.ent.id));
            if (got.ent.prio !== want.ent.prio)
                report("out_priority", 64'(want.ent.prio), 64'(got.ent.prio));
            if (got.ent.desc !== want.ent.desc)
                report("out_desc", 64'(want.ent.desc), 64'(got.ent.desc));
            if (got.last !== want.last)
                report("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   task_priority;
    logic [DESC_W-1:0]   desc_handle;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_id;
    logic [PRIO_W-1:0]   out_priority;
    logic [DESC_W-1:0]   out_desc;
    logic                last;

    queue_tracker tracker = new;
    int           accepted_count = 0;

    sorted_priority_task_queue_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .task_id       (task_id),
        .task_priority (task_priority),
        .desc_handle   (desc_handle),
        .done          (done),
        .status        (status),
        .out_id        (out_id),
        .out_priority  (out_priority),
        .out_desc      (out_desc),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample handshakes and results on the rising edge
    always @(posedge clk)
    begin
        queue_result_t got;
        if (rst_n && start && !busy)
        begin
            tracker.note_command(func, {task_id, task_priority, desc_handle});
            accepted_count++;
        end
        if (rst_n && done)
        begin
            got.status = status;
            got.ent    = {out_id, out_priority, out_desc};
            got.last   = last;
            tracker.check_result(got);
        end
    end

    // Present one item and hold it until the block takes it
    task automatic issue(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                         input logic [PRIO_W-1:0] pr, input logic [DESC_W-1:0] d);
        int seen;
        seen = accepted_count;
        start         <= 1'b1;
        func          <= f;
        task_id       <= id;
        task_priority <= pr;
        desc_handle   <= d;
        do
            @(negedge clk);
        while (accepted_count == seen);
    endtask

    // Hold start low for a burst, with noise on the fields
    task automatic idle_burst(input int cycles);
        start         <= 1'b0;
        func          <= FUNC_W'($urandom);
        task_id       <= ID_W'($urandom);
        task_priority <= PRIO_W'($urandom);
        desc_handle   <= $urandom;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic random_item(input int mode);
        logic [FUNC_W-1:0] f;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] pr;
        int                r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
                f = (r < 70) ? FUNC_ADD : (r < 80) ? FUNC_POP : (r < 90) ? FUNC_REMOVE : FUNC_VIEW;
            MODE_DRAIN:
                f = (r < 15) ? FUNC_ADD : (r < 55) ? FUNC_POP : (r < 85) ? FUNC_REMOVE : FUNC_VIEW;
            default:
                f = (r < 40) ? FUNC_ADD : (r < 60) ? FUNC_POP : (r < 80) ? FUNC_REMOVE : FUNC_VIEW;
        endcase
        // Keep ids in a small pool most of the time so removes hit
        id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 11));
        case ($urandom_range(0, 5))
            0: pr = '0;
            1: pr = '1;
            2, 3: pr = PRIO_W'($urandom);
            default: pr = PRIO_W'($urandom_range(0, 3));
        endcase
        issue(f, id, pr, $urandom);
    endtask

    initial
    begin
        int issued;
        int phase_len;
        int mode;
        bit quiet;
        start         = 1'b0;
        func          = FUNC_ADD;
        task_id       = '0;
        task_priority = '0;
        desc_handle   = '0;
        rst_n         = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Operations on an empty queue
        issue(FUNC_VIEW, 16'h0000, 8'h00, 32'h0000_0000);
        issue(FUNC_POP, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        idle_burst(3);
        issue(FUNC_REMOVE, 16'h0000, 8'h00, 32'h0000_0000);

        // Extremes and equal priorities, which must stay in arrival order
        issue(FUNC_ADD, 16'hFFFF, 8'h00, 32'h0000_0000);
        issue(FUNC_ADD, 16'h0000, 8'hFF, 32'hFFFF_FFFF);
        issue(FUNC_ADD, 16'h0001, 8'hFF, 32'hA5A5_A5A5);
        idle_burst(1);
        issue(FUNC_ADD, 16'h0002, 8'h00, 32'h5A5A_5A5A);
        issue(FUNC_ADD, 16'h0003, 8'h80, 32'h1234_5678);
        issue(FUNC_ADD, 16'hFFFF, 8'h80, 32'h8765_4321);
        issue(FUNC_VIEW, 16'h0000, 8'h00, 32'h0000_0000);

        // Duplicate id removes the one nearest the head; then a miss
        issue(FUNC_REMOVE, 16'hFFFF, 8'h00, 32'h0000_0000);
        issue(FUNC_REMOVE, 16'h1234, 8'h00, 32'h0000_0000);
        idle_burst(7);
        issue(FUNC_POP, 16'h0000, 8'h00, 32'h0000_0000);
        issue(FUNC_VIEW, 16'h0000, 8'h00, 32'h0000_0000);

        // Random phases that fill, drain or mix, idling in bursts
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(10, 40);
            mode      = $urandom_range(MODE_FILL, MODE_MIXED);
            quiet     = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && issued < RANDOM_ITEMS; k++)
            begin
                if (!quiet && issued < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 9) < 3)
                    idle_burst($urandom_range(1, 15));
                random_item(mode);
                issued++;
            end
        end
        start <= 1'b0;

        // Let outstanding results drain, then allow for a late stray one
        while (tracker.expected.size() != 0)
            @(negedge clk);
        repeat (QUEUE_DEPTH + 4) @(negedge clk);

        if (tracker.failures == 0 && tracker.expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
